### rtl/pwsr_pkg.sv
// Shared types and constants of the wheel speed regulator.
package pwsr_pkg;

  // Field and register widths
  localparam int GAIN_W    = 20;
  localparam int LIMIT_W   = 10;
  localparam int IVL_W     = 16;
  localparam int DRIVE_W   = 11;
  localparam int SUM_W     = 40;
  localparam int DERIV_W   = 41;
  localparam int OP_W      = 48;
  localparam int CHUNK_W   = 16;
  localparam int PROD_W    = 38;
  localparam int ACC_W     = 80;
  localparam int FRAC_SH   = 16;
  localparam int FIN_W     = ACC_W - FRAC_SH;
  localparam int DRIVE_FRAC = 20;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int OUT_DATA_W = 16;

  // Register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_FF_GAIN     = 3'd3;
  localparam logic [2:0] REG_MIN_DRIVE   = 3'd4;
  localparam logic [2:0] REG_MAX_DRIVE   = 3'd5;

  localparam logic [LIMIT_W-1:0] MAX_DRIVE_RESET = 10'd255;

  // Terms of the drive sum, in the order they are accumulated
  localparam logic [1:0] TERM_P  = 2'd0;
  localparam logic [1:0] TERM_I  = 2'd1;
  localparam logic [1:0] TERM_D  = 2'd2;
  localparam logic [1:0] TERM_FF = 2'd3;

  localparam logic [1:0] CHUNK_LAST = 2'd2;

  // Saturation bounds
  localparam logic signed [63:0] SUM_MAX = 64'sd549755813887;
  localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
  localparam logic [SUM_W-1:0]   DERIV_MAG_MAX = '1;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [GAIN_W-1:0]  ff_gain;
    logic [LIMIT_W-1:0] min_drive;
    logic [LIMIT_W-1:0] max_drive;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       calc_err;
    logic       div_init;
    logic       calc_cand;
    logic       div_step;
    logic       deriv_sat;
    logic       mac_mul;
    logic       mac_add;
    logic [1:0] term;
    logic [1:0] chunk;
    logic       fin_offset;
    logic       fin_store;
    logic       small_store;
  } cmd_t;

  typedef struct packed {
    logic near_zero;
    logic out_free;
  } sts_t;

endpackage

### rtl/pid_wheel_speed_regulator_top.sv
// Top level of the wheel speed regulator: stream ports, register port, sequencer and datapath.
//
// PID speed loop of one wheel with feedforward on the target, a deadband offset,
// symmetric limits and conditional-integration anti-windup. Each request carries a
// target and a measured speed (signed, 12 fraction bits, m/s) and the update interval
// (seconds times 65536, zero taken as one) and yields one result: a signed drive and a
// flag that the drive sits at the limit, in which case the integral is held. A target
// within four codes of zero clears the integral and the stored error and gives a zero
// drive. The restoring divider for the derivative takes one quotient bit a cycle over
// SPEED_WIDTH+18 bits, and the four gain products share one 20 by 17 bit multiplier
// over twelve multiply/accumulate pairs. A new request is taken while the previous
// result still waits in the output register. Gains and limits are to be written by
// the user over the register port only while no request is in progress; the block
// does not enforce this. Register i sits at byte address 4*i.
module pid_wheel_speed_regulator_top
  import pwsr_pkg::*;
#(
  parameter int SPEED_WIDTH = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // target_speed, measured_speed, interval (from bit 0 up), zero padding
  input  logic [((2*SPEED_WIDTH+IVL_W+7)/8)*8-1:0] s_tdata,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // drive (bits 10:0), zero padding
  output logic [OUT_DATA_W-1:0] m_tdata,
  // limited
  output logic [0:0]            m_tuser,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic signed [SPEED_WIDTH-1:0] target_speed;
  logic signed [SPEED_WIDTH-1:0] measured_speed;
  logic [IVL_W-1:0]              interval;
  logic signed [DRIVE_W-1:0]     drive;
  logic                          limited;

  // Unpack the request fields
  assign target_speed   = $signed(s_tdata[SPEED_WIDTH-1:0]);
  assign measured_speed = $signed(s_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]);
  assign interval       = s_tdata[2*SPEED_WIDTH+IVL_W-1:2*SPEED_WIDTH];

  // Pack the result
  assign m_tdata    = {{(OUT_DATA_W-DRIVE_W){1'b0}}, drive};
  assign m_tuser[0] = limited;

  pwsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence each request: error, divide, four products, offset and clamp; a near-zero target skips to a zero result
  pwsr_ctrl #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the loop state and the result register
  pwsr_dp #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .interval       (interval),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .drive          (drive),
    .limited        (limited)
  );

endmodule

### rtl/pwsr_cfg.sv
// Register bank of the wheel speed regulator behind its APB-style port.
module pwsr_cfg
  import pwsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= '0;
      cfg.integ_gain <= '0;
      cfg.deriv_gain <= '0;
      cfg.ff_gain    <= '0;
      cfg.min_drive  <= '0;
      cfg.max_drive  <= MAX_DRIVE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROP_GAIN:  cfg.prop_gain  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain <= pwdata[GAIN_W-1:0];
        REG_FF_GAIN:    cfg.ff_gain    <= pwdata[GAIN_W-1:0];
        REG_MIN_DRIVE:  cfg.min_drive  <= pwdata[LIMIT_W-1:0];
        REG_MAX_DRIVE:  cfg.max_drive  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = DATA_W'(cfg.prop_gain);
      REG_INTEG_GAIN: prdata = DATA_W'(cfg.integ_gain);
      REG_DERIV_GAIN: prdata = DATA_W'(cfg.deriv_gain);
      REG_FF_GAIN:    prdata = DATA_W'(cfg.ff_gain);
      REG_MIN_DRIVE:  prdata = DATA_W'(cfg.min_drive);
      REG_MAX_DRIVE:  prdata = DATA_W'(cfg.max_drive);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/pwsr_ctrl.sv
// Sequencer of the wheel speed regulator: steps the datapath through one request.
module pwsr_ctrl
  import pwsr_pkg::*;
#(
  parameter int SPEED_WIDTH = 16
)
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int DIV_W = SPEED_WIDTH + 18;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_SMALL = 4'd2;
  localparam logic [3:0] ST_DINIT = 4'd3;
  localparam logic [3:0] ST_CAND  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_DSAT  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_ADD   = 4'd8;
  localparam logic [3:0] ST_FIN1  = 4'd9;
  localparam logic [3:0] ST_FIN2  = 4'd10;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic [1:0]       term, term_next;
  logic [1:0]       chunk, chunk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      term    <= TERM_P;
      chunk   <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      term    <= term_next;
      chunk   <= chunk_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    term_next    = term;
    chunk_next   = chunk;
    cmd          = '0;
    cmd.term     = term;
    cmd.chunk    = chunk;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = sts.near_zero ? ST_SMALL : ST_DINIT;
      end
      ST_SMALL: begin
        if (sts.out_free) begin
          cmd.small_store = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_CAND;
      end
      ST_CAND: begin
        cmd.calc_cand = 1'b1;
        div_cnt_next  = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(DIV_W - 1)) begin
          state_next = ST_DSAT;
        end
      end
      ST_DSAT: begin
        cmd.deriv_sat = 1'b1;
        term_next     = TERM_P;
        chunk_next    = '0;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mac_mul = 1'b1;
        state_next  = ST_ADD;
      end
      ST_ADD: begin
        cmd.mac_add = 1'b1;
        state_next  = ST_MUL;
        if (chunk == CHUNK_LAST) begin
          chunk_next = '0;
          term_next  = term + 2'd1;
          if (term == TERM_FF) begin
            state_next = ST_FIN1;
          end
        end else begin
          chunk_next = chunk + 2'd1;
        end
      end
      ST_FIN1: begin
        cmd.fin_offset = 1'b1;
        state_next     = ST_FIN2;
      end
      ST_FIN2: begin
        if (sts.out_free) begin
          cmd.fin_store = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/pwsr_dp.sv
// Datapath of the wheel speed regulator: divider, shared multiplier, accumulator, state.
module pwsr_dp
  import pwsr_pkg::*;
#(
  parameter int SPEED_WIDTH = 16
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic signed [SPEED_WIDTH-1:0] target_speed,
  input  logic signed [SPEED_WIDTH-1:0] measured_speed,
  input  logic [IVL_W-1:0]              interval,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic signed [DRIVE_W-1:0]     drive,
  output logic                          limited
);

  localparam int SW    = SPEED_WIDTH;
  localparam int ERR_W = SW + 1;
  localparam int DE_W  = SW + 2;
  localparam int DIV_W = SW + 18;
  localparam int EP_W  = SW + 18;
  localparam int CS_W  = ((EP_W > SUM_W) ? EP_W : SUM_W) + 1;
  localparam logic signed [SW-1:0] SMALL_LIM = SW'(4);

  logic signed [SW-1:0]     tgt_r, meas_r;
  logic [IVL_W-1:0]         ivl_r;
  logic signed [ERR_W-1:0]  err_r, prev_err;
  logic signed [SUM_W-1:0]  error_sum, cand_r;
  logic signed [EP_W-1:0]   errprod_r;
  logic [DIV_W-1:0]         quo_r;
  logic [IVL_W-1:0]         rem_r;
  logic                     neg_r;
  logic signed [DERIV_W-1:0] deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [1:0]               pos_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [FIN_W-1:0]  fin_r;

  // Error change and its magnitude
  logic signed [DE_W-1:0] de;
  logic [DE_W-1:0]        de_mag;
  assign de     = DE_W'(err_r) - DE_W'(prev_err);
  assign de_mag = de[DE_W-1] ? DE_W'(-de) : DE_W'(de);

  // Candidate integral
  logic signed [CS_W-1:0] cand_sum;
  assign cand_sum = CS_W'(error_sum) + CS_W'(errprod_r);

  // Restoring divider, one quotient bit a cycle
  logic [IVL_W:0] rem_sh;
  logic           fits;
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, ivl_r};

  // Derivative saturation
  logic [63:0]      quo64;
  logic [SUM_W-1:0] dmag;
  assign quo64 = 64'(quo_r);
  assign dmag  = (quo64 > 64'(DERIV_MAG_MAX)) ? DERIV_MAG_MAX : quo64[SUM_W-1:0];

  // Shared multiplier: gain times one 16-bit slice of the operand
  logic signed [OP_W-1:0]    op;
  logic [GAIN_W-1:0]         gain;
  logic signed [CHUNK_W:0]   slice;
  logic signed [PROD_W-1:0]  prod_c;
  always_comb begin
    case (cmd.term)
      TERM_P: begin
        op   = OP_W'(err_r);
        gain = cfg.prop_gain;
      end
      TERM_I: begin
        op   = OP_W'(cand_r);
        gain = cfg.integ_gain;
      end
      TERM_D: begin
        op   = OP_W'(deriv_r);
        gain = cfg.deriv_gain;
      end
      default: begin
        op   = OP_W'(tgt_r);
        gain = cfg.ff_gain;
      end
    endcase
    case (cmd.chunk)
      2'd0:    slice = $signed({1'b0, op[CHUNK_W-1:0]});
      2'd1:    slice = $signed({1'b0, op[2*CHUNK_W-1:CHUNK_W]});
      default: slice = $signed({op[OP_W-1], op[OP_W-1:2*CHUNK_W]});
    endcase
  end
  assign prod_c = PROD_W'($signed({1'b0, gain})) * PROD_W'(slice);

  // Deadband offset
  logic signed [FIN_W-1:0] acc_fl, md;
  assign acc_fl = $signed(acc_r[ACC_W-1:FRAC_SH]);
  assign md     = $signed(FIN_W'({cfg.min_drive, {DRIVE_FRAC{1'b0}}}));

  // Clamp and truncate toward zero
  logic signed [FIN_W-1:0] lim, clamped, cmag;
  logic                    at_lim;
  logic signed [DRIVE_W-1:0] drive_c;
  always_comb begin
    lim = $signed(FIN_W'({cfg.max_drive, {DRIVE_FRAC{1'b0}}}));
    at_lim = 1'b1;
    if (fin_r >= lim) begin
      clamped = lim;
    end else if (fin_r <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = fin_r;
      at_lim  = 1'b0;
    end
    cmag = clamped[FIN_W-1] ? -clamped : clamped;
    drive_c = clamped[FIN_W-1] ?
              -$signed({1'b0, cmag[DRIVE_FRAC+LIMIT_W-1:DRIVE_FRAC]}) :
               $signed({1'b0, cmag[DRIVE_FRAC+LIMIT_W-1:DRIVE_FRAC]});
  end

  assign sts.near_zero = (tgt_r >= -SMALL_LIM) && (tgt_r <= SMALL_LIM);
  assign sts.out_free  = !m_tvalid || m_tready;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r  <= target_speed;
      meas_r <= measured_speed;
      ivl_r  <= (interval == '0) ? IVL_W'(1) : interval;
    end
    if (cmd.calc_err) begin
      err_r <= ERR_W'(tgt_r) - ERR_W'(meas_r);
    end
    if (cmd.div_init) begin
      neg_r     <= de[DE_W-1];
      quo_r     <= {de_mag, {IVL_W{1'b0}}};
      rem_r     <= '0;
      errprod_r <= EP_W'(err_r) * EP_W'($signed({1'b0, ivl_r}));
      acc_r     <= '0;
    end
    if (cmd.calc_cand) begin
      if (cand_sum > CS_W'(SUM_MAX)) begin
        cand_r <= SUM_W'(SUM_MAX);
      end else if (cand_sum < CS_W'(SUM_MIN)) begin
        cand_r <= SUM_W'(SUM_MIN);
      end else begin
        cand_r <= SUM_W'(cand_sum);
      end
    end
    if (cmd.div_step) begin
      rem_r <= fits ? IVL_W'(rem_sh - {1'b0, ivl_r}) : rem_sh[IVL_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
    if (cmd.deriv_sat) begin
      deriv_r <= neg_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    end
    if (cmd.mac_mul) begin
      prod_r <= prod_c;
      // Integral term keeps its 16 extra fraction bits, the others sit one slice up
      pos_r  <= cmd.chunk + ((cmd.term != TERM_I) ? 2'd1 : 2'd0);
    end
    if (cmd.mac_add) begin
      acc_r <= acc_r + (ACC_W'(prod_r) <<< {pos_r, 4'b0000});
    end
    if (cmd.fin_offset) begin
      if (acc_fl > 0) begin
        fin_r <= acc_fl + md;
      end else if (acc_fl < 0) begin
        fin_r <= acc_fl - md;
      end else begin
        fin_r <= acc_fl;
      end
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst || cmd.small_store) begin
      error_sum <= '0;
      prev_err  <= '0;
    end else if (cmd.fin_store) begin
      prev_err <= err_r;
      if (!at_lim) begin
        error_sum <= cand_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.fin_store || cmd.small_store) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.small_store) begin
      drive   <= '0;
      limited <= 1'b0;
    end else if (cmd.fin_store) begin
      drive   <= drive_c;
      limited <= at_lim;
    end
  end

endmodule

### bench/pid_wheel_speed_regulator_top_tb.sv
// Self-checking testbench of the wheel speed regulator: directed table, random phases, predictor.
module pid_wheel_speed_regulator_top_tb
  import pwsr_pkg::*;
();

  localparam int SPD_W = 16;
  localparam int IN_W = ((2*SPD_W+IVL_W+7)/8)*8;
  // Generous ceiling for about 1150 requests plus gaps and hold-offs
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES = 10;

  // Integral store bounds (40-bit signed) and derivative magnitude cap
  localparam longint INTEG_TOP = 64'sd549755813887;
  localparam longint INTEG_BOTTOM = -INTEG_TOP - 64'sd1;
  localparam longint DERIV_CAP = 64'sd1099511627775;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               limited;
  } drive_res_t;

  typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

  // One line of the directed table: a register write or a request
  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        value;
    logic signed [15:0] tgt;
    logic signed [15:0] meas;
    logic [15:0]        ivl;
    logic               known;
    drive_res_t         want;
  } row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // target_speed, measured_speed, interval (from bit 0 up)
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // drive (bits 10:0), zero padding
  logic [OUT_DATA_W-1:0] m_tdata;
  // limited
  logic [0:0]        m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predictor copy of the registers and the loop state
  longint g_prop, g_integ, g_deriv, g_ff, g_min, g_max;
  longint integ_sum, last_err;

  drive_res_t drive_due[$];
  row_t       steps[$];

  int  mismatches = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_writes = 0;
  int  hold_ask = 0;
  bit  calm = 1'b0;
  int  windup_dir = 0;
  int  traj_tgt = 8192;
  int  traj_off = 0;
  int  traj_ivl = 655;

  pid_wheel_speed_regulator_top #(.SPEED_WIDTH(SPD_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the drive for one request and advance the loop state.
  // Products stay well inside 64 bits: the largest, deriv gain by a
  // saturated derivative, is under 2^61.
  function automatic drive_res_t regulate(input logic signed [15:0] tgt_in,
                                          input logic signed [15:0] meas_in,
                                          input logic [15:0] ivl_in);
    longint tgt, meas, ivl, err, de, mag, deriv, cand, acc, lim, drv;
    drive_res_t res;
    tgt = tgt_in;
    meas = meas_in;
    ivl = ivl_in;
    if (ivl == 0) ivl = 1;
    // Near-zero target: clear both stores, drive nothing
    if (tgt >= -4 && tgt <= 4) begin
      integ_sum = 0;
      last_err = 0;
      res.drive = '0;
      res.limited = 1'b0;
      return res;
    end
    err = tgt - meas;
    de = err - last_err;
    mag = (de < 0) ? -de : de;
    mag = (mag <<< 16) / ivl;
    if (mag > DERIV_CAP) mag = DERIV_CAP;
    deriv = (de < 0) ? -mag : mag;
    cand = integ_sum + err * ivl;
    if (cand > INTEG_TOP) cand = INTEG_TOP;
    if (cand < INTEG_BOTTOM) cand = INTEG_BOTTOM;
    // 20 fraction bits throughout; integral term floored down from 36
    acc = g_prop * err + ((g_integ * cand) >>> 16) + g_deriv * deriv + g_ff * tgt;
    if (acc > 0) acc += g_min <<< 20;
    else if (acc < 0) acc -= g_min <<< 20;
    lim = g_max <<< 20;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    res.limited = !(acc < lim && acc > -lim);
    if (!res.limited) integ_sum = cand;
    last_err = err;
    drv = (acc < 0) ? -((-acc) >>> 20) : (acc >>> 20);
    res.drive = drv[DRIVE_W-1:0];
    return res;
  endfunction

  function automatic row_t wr(input logic [2:0] idx, input int unsigned value);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t rq(input int t, input int m, input int iv);
    row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.tgt = t[15:0];
    r.meas = m[15:0];
    r.ivl = iv[15:0];
    return r;
  endfunction

  function automatic row_t rq_known(input int t, input int m, input int iv,
                                    input int drv, input logic lim);
    row_t r;
    r = rq(t, m, iv);
    r.known = 1'b1;
    r.want.drive = drv[DRIVE_W-1:0];
    r.want.limited = lim;
    return r;
  endfunction

  // Gain spread over many magnitudes, from zero up to the full width
  function automatic int unsigned pick_scaled(input int bits);
    return $urandom & ((32'd1 << $urandom_range(0, bits)) - 32'd1);
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %0s at result %0d: expected %0d, got %0d",
               what, n_checked, want, got);
  endfunction

  // Register write over the APB-style port: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  g_prop = value[GAIN_W-1:0];
      REG_INTEG_GAIN: g_integ = value[GAIN_W-1:0];
      REG_DERIV_GAIN: g_deriv = value[GAIN_W-1:0];
      REG_FF_GAIN:    g_ff = value[GAIN_W-1:0];
      REG_MIN_DRIVE:  g_min = value[LIMIT_W-1:0];
      REG_MAX_DRIVE:  g_max = value[LIMIT_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Offer one request, hold it until taken, then log its expected drive.
  // Valid is left high on return so back-to-back requests need no re-raise.
  task automatic offer(input logic signed [15:0] t, input logic signed [15:0] m,
                       input logic [15:0] iv, input logic known, input drive_res_t fixed);
    drive_res_t calc;
    if (!calm && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({iv, m, t});
    do @(posedge clk); while (!s_tready);
    calc = regulate(t, m, iv);
    drive_due.push_back(known ? fixed : calc);
    n_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // Random request: wind-up drive in its phases, else mostly a settling speed loop, some noise, some near-zero targets
  task automatic next_req(output logic signed [15:0] t, output logic signed [15:0] m,
                          output logic [15:0] iv);
    int r, v;
    r = $urandom_range(99);
    if (windup_dir != 0) begin
      // Largest error of one sign at the longest interval pushes the integral to its bound
      t = (windup_dir > 0) ? 16'sh7FFF : 16'sh8000;
      m = (windup_dir > 0) ? 16'sh8000 : 16'sh7FFF;
      iv = 16'hFFFF;
    end else if (r < 72) begin
      if ($urandom_range(19) == 0) begin
        traj_tgt = int'($urandom_range(0, 65535)) - 32768;
        traj_off = int'($urandom_range(0, 8191)) - 4096;
        traj_ivl = $urandom_range(100, 8000);
      end
      traj_off = traj_off * 3 / 4 + int'($urandom_range(0, 64)) - 32;
      v = traj_tgt - traj_off;
      t = traj_tgt[15:0];
      m = v[15:0];
      v = traj_ivl + int'($urandom_range(0, 40)) - 20;
      iv = v[15:0];
    end else if (r < 88) begin
      t = 16'($urandom);
      m = 16'($urandom);
      iv = 16'($urandom);
    end else begin
      v = int'($urandom_range(0, 8)) - 4;
      t = v[15:0];
      m = 16'($urandom);
      iv = 16'($urandom);
    end
  endtask

  // Choose and write one register setting per random phase
  task automatic phase_setup(input int p);
    int unsigned gp, gi, gd, gf, mn, mx;
    gp = pick_scaled(GAIN_W);
    gi = pick_scaled(GAIN_W);
    gd = pick_scaled(GAIN_W);
    gf = pick_scaled(GAIN_W);
    mn = pick_scaled(LIMIT_W);
    mx = $urandom_range(1, 1023);
    case (p)
      0: begin
        // everything at its top value
        gp = 20'hFFFFF; gi = 20'hFFFFF; gd = 20'hFFFFF; gf = 20'hFFFFF;
        mn = 1023; mx = 1023;
      end
      1: begin
        // gains of a plausible tuned loop
        gp = pick_scaled(16); gi = pick_scaled(20); gd = pick_scaled(6);
        gf = pick_scaled(14); mn = pick_scaled(6); mx = 255;
      end
      2, 5: begin
        // silent loop: integral winds up unseen
        gp = 0; gi = 0; gd = 0; gf = 0; mn = 0; mx = 1023;
      end
      3, 6: begin
        // small integral gain exposes the saturated store
        gp = (p == 6) ? $urandom_range(0, 4096) : 0;
        gi = $urandom_range(1, 64); gd = 0; gf = 0; mn = 0; mx = 1023;
      end
      4: mx = 1;
      9: mx = 1023;
      default: ;
    endcase
    reg_write(REG_PROP_GAIN, gp);
    reg_write(REG_INTEG_GAIN, gi);
    reg_write(REG_DERIV_GAIN, gd);
    reg_write(REG_FF_GAIN, gf);
    reg_write(REG_MIN_DRIVE, mn);
    reg_write(REG_MAX_DRIVE, mx);
  endtask

  // Result side: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    drive_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_due.size() == 0) begin
        note_mismatch("unexpected result, drive", 0, $signed(m_tdata[DRIVE_W-1:0]));
      end else begin
        want = drive_due.pop_front();
        if (m_tdata[DRIVE_W-1:0] !== want.drive)
          note_mismatch("drive", $signed(want.drive), $signed(m_tdata[DRIVE_W-1:0]));
        if (m_tuser[0] !== want.limited)
          note_mismatch("limited", want.limited, m_tuser[0]);
      end
      n_checked++;
    end
  end

  // Receiver: random stalls, none in calm stretches, long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, drive_due.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] t, m;
    logic [15:0] iv;
    int n_directed, count;
    g_prop = 0; g_integ = 0; g_deriv = 0; g_ff = 0; g_min = 0; g_max = MAX_DRIVE_RESET;
    integ_sum = 0;
    last_err = 0;

    // Directed table; known results only where they follow at a glance
    steps = '{
      // reset gains are zero: nothing drives
      rq_known(16'sh4000, 0, 655, 0, 1'b0),
      // near-zero target at both edges of the window
      rq_known(4, 16'sh7FFF, 1, 0, 1'b0),
      rq_known(-4, -32768, 16'hFFFF, 0, 1'b0),
      // zero limit: always at the limit, zero interval on the largest error
      wr(REG_MAX_DRIVE, 0),
      rq_known(32767, -32768, 0, 0, 1'b1),
      // feedforward alone at full gain saturates both ways
      wr(REG_MAX_DRIVE, 1023),
      wr(REG_FF_GAIN, 20'hFFFFF),
      rq_known(32767, 32767, 1, 1023, 1'b1),
      rq_known(-32768, -32768, 16'hFFFF, -1023, 1'b1),
      // zero sum takes no deadband offset; one code of error just clears it
      wr(REG_FF_GAIN, 0),
      wr(REG_PROP_GAIN, 20'hFFFFF),
      wr(REG_MIN_DRIVE, 100),
      rq_known(5, 5, 1000, 0, 1'b0),
      rq_known(5, 4, 1000, 100, 1'b0),
      rq_known(5, 6, 1000, -100, 1'b0),
      // full integral and derivative gain on extreme errors and intervals
      wr(REG_INTEG_GAIN, 20'hFFFFF),
      wr(REG_DERIV_GAIN, 20'hFFFFF),
      rq(32767, -32768, 0),
      rq(-32768, 32767, 16'hFFFF),
      rq(16'sh1000, 16'sh0FFF, 1),
      rq(-5, 0, 16'h8000),
      rq_known(0, 0, 0, 0, 1'b0),
      // top offset against the smallest limit
      wr(REG_MIN_DRIVE, 1023),
      wr(REG_MAX_DRIVE, 1),
      rq(100, 99, 3),
      rq(-100, 99, 65535)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_WRITE) begin
        settle();
        reg_write(steps[i].idx, steps[i].value);
      end else begin
        offer(steps[i].tgt, steps[i].meas, steps[i].ivl, steps[i].known, steps[i].want);
      end
    end
    n_directed = n_sent;

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      phase_setup(p);
      calm = (p == 1);
      windup_dir = (p == 2) ? 1 : ((p == 5) ? -1 : 0);
      case (p)
        1: count = 150;
        2, 5: count = 140;
        6: count = 80;
        default: count = 100;
      endcase
      for (int k = 0; k < count; k++) begin
        // starve the output for a long stretch while requests keep coming
        if (k == 10 && (p == 3 || p == 8)) hold_ask = HOLD_CYCLES;
        next_req(t, m, iv);
        offer(t, m, iv, 1'b0, '0);
      end
    end

    calm = 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d from the table) under %0d register writes, %0d results",
             n_sent, n_directed, n_writes, n_checked);
    $display("incl. integral wind-up both ways, output hold-offs, %0d mismatches", mismatches);
    if (mismatches == 0 && drive_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
